>>> rtl/text_console_writer_defines.svh
// assertion macros shared by the console checker
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// condition implies consequence in the same cycle
`define TCW_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tcw_pkg.sv
// shared types and constants of the text console writer
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int DEF_SCREEN_ROWS = 25;
  localparam int DEF_SCREEN_COLS = 80;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int CELL_W  = 16;
  localparam int TAB_STEP = 8;

  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;

  localparam logic [BYTE_W-1:0] RESET_COLOR = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL  = {RESET_COLOR, CH_SPACE};

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_SET   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_SCROLL_LAST,
    ST_BLANK,
    ST_CLEAR,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    MEM_IDLE,
    MEM_INIT,
    MEM_EXEC,
    MEM_COPY,
    MEM_DRAIN,
    MEM_BLANK
  } mem_op_t;

  // controller to datapath
  typedef struct packed {
    logic    latch;
    logic    exec;
    logic    sweep_clr;
    logic    sweep_bottom;
    logic    sweep_inc;
    logic    load_res;
    logic    load_from_next;
    mem_op_t mem_op;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    req_t req;
    logic need_scroll;
    logic at_copy_end;
    logic at_end;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/tcw_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/tcw_controller.sv
// sequencing state machine of the text console writer
`timescale 1ns / 1ps
`default_nettype none

module tcw_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tcw_pkg::status_t status,
  output tcw_pkg::cmd_t    cmd
);

  import tcw_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (status.at_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.need_scroll) begin
          state_next = ST_SCROLL;
        end else if (status.req == REQ_CLEAR) begin
          state_next = ST_CLEAR;
        end else if (status.req == REQ_READ || !status.out_free) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCROLL: begin
        if (status.at_copy_end) state_next = ST_SCROLL_LAST;
      end
      ST_SCROLL_LAST: begin
        state_next = ST_BLANK;
      end
      ST_BLANK, ST_CLEAR: begin
        if (status.at_end) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.mem_op = MEM_IDLE;
    in_ready = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.mem_op    = MEM_INIT;
        cmd.sweep_inc = 1'b1;
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.sweep_clr = 1'b1;
        cmd.mem_op    = MEM_EXEC;
        // short requests finish here when the output register is free
        if (!status.need_scroll && status.req != REQ_CLEAR &&
            status.req != REQ_READ && status.out_free) begin
          cmd.load_res       = 1'b1;
          cmd.load_from_next = 1'b1;
        end
      end
      ST_SCROLL: begin
        cmd.mem_op    = MEM_COPY;
        cmd.sweep_inc = 1'b1;
      end
      ST_SCROLL_LAST: begin
        cmd.mem_op       = MEM_DRAIN;
        cmd.sweep_bottom = 1'b1;
      end
      ST_BLANK, ST_CLEAR: begin
        cmd.mem_op    = MEM_BLANK;
        cmd.sweep_inc = 1'b1;
      end
      ST_FINISH: begin
        cmd.load_res = status.out_free;
      end
      default: begin
        cmd.mem_op = MEM_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/tcw_datapath.sv
// cursor, screen store and result register of the text console writer
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath #(
  parameter int SCREEN_ROWS = tcw_pkg::DEF_SCREEN_ROWS,
  parameter int SCREEN_COLS = tcw_pkg::DEF_SCREEN_COLS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tcw_pkg::cmd_t               cmd,
  output tcw_pkg::status_t            status,
  input  logic [tcw_pkg::BYTE_W-1:0]  text_color,
  input  tcw_pkg::req_t               in_req,
  input  logic [tcw_pkg::BYTE_W-1:0]  in_char,
  input  logic [tcw_pkg::ROW_W-1:0]   in_row,
  input  logic [tcw_pkg::COL_W-1:0]   in_col,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcw_pkg::ROW_W-1:0]   out_row,
  output logic [tcw_pkg::COL_W-1:0]   out_col,
  output logic [tcw_pkg::BYTE_W-1:0]  out_char,
  output logic [tcw_pkg::BYTE_W-1:0]  out_color
);

  import tcw_pkg::*;

  localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLS;
  localparam int AW  = $clog2(CELL_COUNT);
  localparam int RW  = $clog2(SCREEN_ROWS);
  localparam int CW  = $clog2(SCREEN_COLS);
  localparam int CXW = CW + 1;

  // latched request
  req_t              lat_req;
  logic [BYTE_W-1:0] lat_char;
  logic [RW-1:0]     lat_row;
  logic [CW-1:0]     lat_col;

  // cursor
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row_next;
  logic [CW-1:0] cur_col_next;

  // put character decode
  logic [CXW-1:0]    col_ext;
  logic [CXW-1:0]    tab_col;
  logic [CXW-1:0]    inc_col;
  logic [RW-1:0]     put_row_next;
  logic [CW-1:0]     put_col_next;
  logic              put_lf;
  logic              put_scroll;
  logic              put_we;
  logic [RW-1:0]     put_row;
  logic [CW-1:0]     put_col;
  logic [BYTE_W-1:0] put_byte;

  // store access
  logic [RW-1:0]     exec_row;
  logic [CW-1:0]     exec_col;
  logic [AW-1:0]     exec_addr;
  logic [AW-1:0]     sweep;
  logic              pend_valid;
  logic [AW-1:0]     pend_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // latch the request with positions saturated to the screen
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat_req  <= in_req;
      lat_char <= in_char;
      lat_row  <= (32'(in_row) >= SCREEN_ROWS) ? RW'(SCREEN_ROWS - 1) : RW'(in_row);
      lat_col  <= (32'(in_col) >= SCREEN_COLS) ? CW'(SCREEN_COLS - 1) : CW'(in_col);
    end
  end

  // put character: cursor movement and cell write
  always_comb begin
    col_ext      = {1'b0, cur_col};
    tab_col      = (col_ext | CXW'(TAB_STEP - 1)) + CXW'(1);
    inc_col      = col_ext + CXW'(1);
    put_row_next = cur_row;
    put_col_next = cur_col;
    put_lf       = 1'b0;
    put_scroll   = 1'b0;
    put_we       = 1'b0;
    put_row      = cur_row;
    put_col      = cur_col;
    put_byte     = lat_char;
    case (lat_char)
      CH_NEWLINE: begin
        put_lf = 1'b1;
      end
      CH_TAB: begin
        if (32'(tab_col) >= SCREEN_COLS) begin
          put_lf = 1'b1;
        end else begin
          put_col_next = CW'(tab_col);
        end
      end
      CH_BACKSPACE: begin
        // steps back across a line start, stays at the top left corner
        if (cur_col != '0) begin
          put_col_next = cur_col - CW'(1);
        end else if (cur_row != '0) begin
          put_row_next = cur_row - RW'(1);
          put_col_next = CW'(SCREEN_COLS - 1);
        end
        put_we   = 1'b1;
        put_byte = CH_SPACE;
        put_row  = put_row_next;
        put_col  = put_col_next;
      end
      default: begin
        put_we = 1'b1;
        if (32'(inc_col) >= SCREEN_COLS) begin
          put_lf = 1'b1;
        end else begin
          put_col_next = CW'(inc_col);
        end
      end
    endcase
    // line feed, scrolling on the bottom line
    if (put_lf) begin
      put_col_next = '0;
      if (cur_row == RW'(SCREEN_ROWS - 1)) begin
        put_scroll = 1'b1;
      end else begin
        put_row_next = cur_row + RW'(1);
      end
    end
  end

  // cursor after the request
  always_comb begin
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    case (lat_req)
      REQ_PUT: begin
        cur_row_next = put_row_next;
        cur_col_next = put_col_next;
      end
      REQ_SET: begin
        cur_row_next = lat_row;
        cur_col_next = lat_col;
      end
      REQ_CLEAR: begin
        cur_row_next = '0;
        cur_col_next = '0;
      end
      default: begin
        cur_row_next = cur_row;
        cur_col_next = cur_col;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
    end else if (cmd.exec) begin
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
    end
  end

  // sweep counter for init, scroll and clear passes
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (cmd.sweep_clr) begin
      sweep <= '0;
    end else if (cmd.sweep_bottom) begin
      sweep <= AW'(CELL_COUNT - SCREEN_COLS);
    end else if (cmd.sweep_inc) begin
      sweep <= sweep + AW'(1);
    end
  end

  // copy pipeline: a cell read in one cycle is written one line up in the next
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= (cmd.mem_op == MEM_COPY);
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= sweep;
  end

  // cell address of a put or read request
  assign exec_row  = (lat_req == REQ_READ) ? lat_row : put_row;
  assign exec_col  = (lat_req == REQ_READ) ? lat_col : put_col;
  assign exec_addr = AW'(32'(exec_row) * 32'(SCREEN_COLS) + 32'(exec_col));

  // store port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep;
    mem_wdata = {text_color, CH_SPACE};
    mem_re    = 1'b0;
    mem_raddr = exec_addr;
    unique case (cmd.mem_op)
      MEM_IDLE: begin
        mem_we = 1'b0;
      end
      MEM_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_CELL;
      end
      MEM_EXEC: begin
        mem_we    = (lat_req == REQ_PUT) && put_we;
        mem_waddr = exec_addr;
        mem_wdata = {text_color, put_byte};
        mem_re    = (lat_req == REQ_READ);
      end
      MEM_COPY: begin
        mem_re    = 1'b1;
        mem_raddr = sweep + AW'(SCREEN_COLS);
        mem_we    = pend_valid;
        mem_waddr = pend_addr;
        mem_wdata = mem_rdata;
      end
      MEM_DRAIN: begin
        mem_we    = pend_valid;
        mem_waddr = pend_addr;
        mem_wdata = mem_rdata;
      end
      MEM_BLANK: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_res) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      out_row   <= ROW_W'(cmd.load_from_next ? cur_row_next : cur_row);
      out_col   <= COL_W'(cmd.load_from_next ? cur_col_next : cur_col);
      out_char  <= (lat_req == REQ_READ) ? mem_rdata[BYTE_W-1:0] : '0;
      out_color <= (lat_req == REQ_READ) ? mem_rdata[CELL_W-1:BYTE_W] : '0;
    end
  end

  // status to the controller
  assign status.req         = lat_req;
  assign status.need_scroll = (lat_req == REQ_PUT) && put_scroll;
  assign status.at_copy_end = (sweep == AW'(CELL_COUNT - SCREEN_COLS - 1));
  assign status.at_end      = (sweep == AW'(CELL_COUNT - 1));
  assign status.out_free    = !out_valid || out_ready;

endmodule

`default_nettype wire

>>> rtl/text_console_writer.sv
// Text console writer: keeps a SCREEN_ROWS x SCREEN_COLS character-cell store
// (char in the low byte, attribute in the high byte) and a cursor, and answers
// each request item with one result item carrying the cursor and, for a cell
// read, the cell's bytes. After reset a fill pass writes every cell, one per
// cycle, while no item is taken. Set cursor and put of a newline, tab,
// backspace or glyph finish in the execute state; a cell read goes on to the
// finish state, since the store read is registered. A put that leaves the
// bottom line scrolls: the store, with its separate read and write ports,
// moves one cell per cycle, then blanks the last line. Clear screen blanks
// one cell per cycle. A waiting result does not keep the next item from being
// taken, but that item then holds in its last cycle until the result register
// is free.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer #(
  parameter int SCREEN_ROWS = tcw_pkg::DEF_SCREEN_ROWS,
  parameter int SCREEN_COLS = tcw_pkg::DEF_SCREEN_COLS
) (
  input  logic        clk,
  input  logic        rst,
  // request items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // char_code[7:0], pos_row[12:8], pos_col[19:13], zero
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // cursor_row[4:0], cursor_col[11:5], cell_char[19:12],
                                     // cell_color[27:20], zero
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import tcw_pkg::*;

  localparam logic ADDR_TEXT_COLOR = 1'b0;

  cmd_t              cmd;
  status_t           status;
  logic [BYTE_W-1:0] text_color;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;
  logic [BYTE_W-1:0] out_char;
  logic [BYTE_W-1:0] out_color;

  // register port, the text color register in word 0, word 1 reads zero
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_TEXT_COLOR) begin
      text_color <= pwdata[BYTE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == ADDR_TEXT_COLOR) ? {24'b0, text_color} : 32'b0;

  tcw_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tcw_datapath #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .text_color (text_color),
    .in_req     (req_t'(s_axis_tuser)),
    .in_char    (s_axis_tdata[7:0]),
    .in_row     (s_axis_tdata[12:8]),
    .in_col     (s_axis_tdata[19:13]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_char   (out_char),
    .out_color  (out_color)
  );

  // result item packing
  assign m_axis_tdata = {4'b0, out_color, out_char, out_col, out_row};

endmodule

`default_nettype wire

>>> rtl/tcw_checker.sv
// port-level checks of the text console writer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_writer_defines.svh"

module tcw_checker #(
  parameter int SCREEN_ROWS = 25,
  parameter int SCREEN_COLS = 80
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // fill pass after reset keeps requests out
  `TCW_ASSERT_SAME(a_init_blocks, clk, rst, $past(rst), !s_axis_tready, "item taken during fill pass")

  // one request at a time
  `TCW_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")

  // stalled result stays offered
  `TCW_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

  // reported cursor lies on the screen
  `TCW_ASSERT_SAME(a_col_range, clk, rst, m_axis_tvalid, 32'(m_axis_tdata[11:5]) < SCREEN_COLS, "cursor column off screen")

  `TCW_ASSERT_SAME(a_row_range, clk, rst, m_axis_tvalid, 32'(m_axis_tdata[4:0]) < SCREEN_ROWS, "cursor row off screen")

endmodule

bind text_console_writer tcw_checker #(
  .SCREEN_ROWS (SCREEN_ROWS),
  .SCREEN_COLS (SCREEN_COLS)
) u_tcw_checker (.*);

`default_nettype wire
